FILE: src/sumls_pkg.sv
// Shared constants and operation codes for the sorted unique mode list.
`default_nettype none
package sumls_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Item field widths
  localparam int MODE_W   = 32;
  localparam int OP_W     = 2;
  localparam int STORED_W = 7;
  localparam int OUT_W    = 48;

  // Operation codes carried on in_tuser
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

endpackage
`default_nettype wire

FILE: src/sumls_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module sumls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: src/sorted_unique_mode_list_unit.sv
// From acceptance to the result register: clear and unused codes go straight to finish,
// next reads the table and then finishes, and add scans to the insertion index P, places
// (flagging a full table), shifts the entries from P up, writes the word and then finishes;
// a duplicate ends after the scan. One item at a time; a held result stalls finish.
// Reset (rst_n low, synchronous) empties the table and rewinds the reader;
// no clearing pass: unused table words are never read.
`default_nettype none
module sorted_unique_mode_list_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [sumls_pkg::MODE_W-1:0]     in_tdata,   // [31:0] mode_word
  input  wire logic [sumls_pkg::OP_W-1:0]       in_tuser,   // [1:0] operation
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [31:0] next_mode, [32] entry_found, [33] dropped_full, [40:34] stored_count,
  // [47:41] zero
  output logic      [sumls_pkg::OUT_W-1:0]      out_tdata
);

  import sumls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PLACE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_NEXT_WAIT,
    ST_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      reader_r, reader_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [MODE_W-1:0]     word_r, word_nxt;
  logic [MODE_W-1:0]     res_mode_r, res_mode_nxt;
  logic                  res_found_r, res_found_nxt;
  logic                  res_drop_r, res_drop_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [MODE_W-1:0]     wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [MODE_W-1:0]     rd_data;
  logic [CNT_W-1:0]      k_dec;
  logic [CNT_W+STORED_W-1:0] cnt_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign k_dec      = k_r - 1'b1;
  assign cnt_ext    = {{STORED_W{1'b0}}, count_r};

  // Table storage
  sumls_ram #(
    .WIDTH (MODE_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequence scan, shift, insert and read
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    reader_nxt    = reader_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    word_nxt      = word_r;
    res_mode_nxt  = res_mode_r;
    res_found_nxt = res_found_r;
    res_drop_nxt  = res_drop_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[ADDR_W-1:0];
    wr_data       = word_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[ADDR_W-1:0];

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          word_nxt      = in_tdata;
          res_mode_nxt  = '0;
          res_found_nxt = 1'b0;
          res_drop_nxt  = 1'b0;
          case (in_tuser)
            OP_CLEAR: begin
              count_nxt  = '0;
              reader_nxt = '0;
              state_nxt  = ST_FINISH;
            end
            OP_ADD: begin
              idx_nxt   = '0;
              state_nxt = ST_SCAN_RD;
            end
            OP_NEXT: begin
              if (reader_r < count_r) begin
                rd_en     = 1'b1;
                rd_addr   = reader_r[ADDR_W-1:0];
                state_nxt = ST_NEXT_WAIT;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      // Walk up until an entry not below the word
      ST_SCAN_RD: begin
        if (idx_r == count_r) begin
          state_nxt = ST_PLACE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if ($signed(rd_data) < $signed(word_r)) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end else if (rd_data == word_r) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_PLACE;
        end
      end

      // Flag a full table, else open a slot from the top
      ST_PLACE: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          res_drop_nxt = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          k_nxt     = count_r;
          state_nxt = ST_SHIFT_RD;
        end
      end

      ST_SHIFT_RD: begin
        if (k_r == idx_r) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = k_dec[ADDR_W-1:0];
          state_nxt = ST_SHIFT_WR;
        end
      end

      ST_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = k_r[ADDR_W-1:0];
        wr_data   = rd_data;
        k_nxt     = k_dec;
        state_nxt = ST_SHIFT_RD;
      end

      ST_NEXT_WAIT: begin
        res_mode_nxt  = rd_data;
        res_found_nxt = 1'b1;
        reader_nxt    = reader_r + 1'b1;
        state_nxt     = ST_FINISH;
      end

      // Hold until the result register is free
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt = {{(OUT_W - MODE_W - 2 - STORED_W){1'b0}},
                          cnt_ext[STORED_W-1:0], res_drop_r, res_found_r, res_mode_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      reader_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      reader_r    <= reader_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    word_r      <= word_nxt;
    res_mode_r  <= res_mode_nxt;
    res_found_r <= res_found_nxt;
    res_drop_r  <= res_drop_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
`default_nettype wire
